[hw/rtl/tsp_pkg.sv]
// shared types, constants and small arithmetic helpers for the texel shade pipeline
// no dependencies
`default_nettype none

package tsp_pkg;

  // word handed from the lighting stages to the tint stages
  typedef struct packed {
    logic        valid;
    logic [1:0]  surface;
    logic [23:0] color;
  } lit_t;

  localparam int CHAN_W = 8;
  localparam int BN_W   = 19;
  localparam int SUM_W  = 22;
  localparam int HOUR_W = 9;
  localparam int Q_W    = 12;   // quotient before the final divide by five
  localparam int D5_W   = 10;

  localparam logic [SUM_W-1:0]  BRIGHT_BASE = 22'd131072;   // 0.4
  localparam logic [SUM_W-1:0]  BRIGHT_ONE  = 22'd327680;   // 1.0
  localparam logic [SUM_W-1:0]  DIST_GAIN   = 22'd50;       // 10 in the bright scale
  localparam logic [8:0]        BLEND_ONE   = 9'd256;

  localparam logic [HOUR_W-1:0] HOUR_RESET  = 9'd128;
  localparam logic [HOUR_W-1:0] HOUR_MID    = 9'd128;
  localparam logic [HOUR_W-1:0] HOUR_GREEN0 = 9'd384;
  localparam logic [HOUR_W-1:0] HOUR_BLUE0  = 9'd256;
  localparam logic [10:0]       HOUR_LOW_K  = 11'd1408;

  localparam logic [23:0] RECIP5 = 24'd3277;   // 2^14 / 5, exact for inputs below 2^14

  localparam logic [1:0] SURF_PASS = 2'd0;

  // register index, taken from address bit 2
  localparam logic REG_HOUR = 1'b0;

  function automatic logic [D5_W-1:0] div5(input logic [Q_W-1:0] n);
    logic [23:0] p;
    p = {12'b0, n} * RECIP5;
    return p[23:14];
  endfunction

  function automatic logic [CHAN_W-1:0] sat8(input logic [10:0] v);
    return (v > 11'd255) ? 8'hff : v[7:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tsp_cfg.sv]
// configuration register file: hour of day behind an apb-style port
// uses tsp_pkg
`default_nettype none

module tsp_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output logic      [tsp_pkg::HOUR_W-1:0] hour
);

  logic [tsp_pkg::HOUR_W-1:0] hour_r;
  logic                       hit;

  assign hit    = (paddr[2] == tsp_pkg::REG_HOUR);
  assign pready = 1'b1;
  assign prdata = hit ? {23'b0, hour_r} : 32'b0;
  assign hour   = hour_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r <= tsp_pkg::HOUR_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      hour_r <= pwdata[tsp_pkg::HOUR_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tsp_light.sv]
// brightness and alpha blend, three register stages
// uses tsp_pkg
`default_nettype none

module tsp_light (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_texel_red,
  input  wire logic [7:0]  in_texel_green,
  input  wire logic [7:0]  in_texel_blue,
  input  wire logic [7:0]  in_texel_alpha,
  input  wire logic        in_has_alpha,
  input  wire logic [23:0] in_background,
  input  wire logic [15:0] in_distance,
  input  wire logic [1:0]  in_surface,
  input  wire logic        dn_ready,
  output tsp_pkg::lit_t    dn_word
);

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  logic [tsp_pkg::BN_W-1:0] bn_r;
  logic [16:0]              ptex_r [3];
  logic [15:0]              pbg_r  [3];
  logic [1:0]               surf1_r, surf2_r, surf3_r;
  logic [tsp_pkg::Q_W-1:0]  qtex_r [3];
  logic [tsp_pkg::Q_W-1:0]  qbg_r  [3];
  logic [23:0]              color_r;

  logic [tsp_pkg::SUM_W-1:0] bn_sum;
  logic [tsp_pkg::BN_W-1:0]  bn_nxt;
  logic [8:0]                wt, wb;
  logic [7:0]                tex [3];
  logic [7:0]                bg  [3];
  logic [16:0]               ptex_nxt [3];
  logic [15:0]               pbg_nxt  [3];
  logic [tsp_pkg::Q_W-1:0]   qtex_nxt [3];
  logic [tsp_pkg::Q_W-1:0]   qbg_nxt  [3];
  logic [23:0]               color_nxt;

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  assign dn_word.valid   = v3_r;
  assign dn_word.surface = surf3_r;
  assign dn_word.color   = color_r;

  // stage 1: brightness numerator and channel weights
  always_comb begin
    tex[0] = in_texel_red;
    tex[1] = in_texel_green;
    tex[2] = in_texel_blue;
    bg[0]  = in_background[23:16];
    bg[1]  = in_background[15:8];
    bg[2]  = in_background[7:0];
    bn_sum = tsp_pkg::BRIGHT_BASE + 22'(in_distance) * tsp_pkg::DIST_GAIN;
    bn_nxt = (bn_sum > tsp_pkg::BRIGHT_ONE) ? tsp_pkg::BRIGHT_ONE[tsp_pkg::BN_W-1:0]
                                            : bn_sum[tsp_pkg::BN_W-1:0];
    // no alpha: full weight on the texel, none on the background
    wt = in_has_alpha ? {1'b0, in_texel_alpha} : tsp_pkg::BLEND_ONE;
    wb = in_has_alpha ? (tsp_pkg::BLEND_ONE - {1'b0, in_texel_alpha}) : 9'd0;
    for (int i = 0; i < 3; i++) begin
      ptex_nxt[i] = {9'b0, tex[i]} * {8'b0, wt};
      pbg_nxt[i]  = {8'b0, bg[i]} * {7'b0, wb};
    end
  end

  // stage 2: scale by brightness, drop the 2^24 part of the divisor
  always_comb begin
    logic [35:0] mt, mb;
    for (int i = 0; i < 3; i++) begin
      mt = {19'b0, ptex_r[i]} * {17'b0, bn_r};
      mb = {20'b0, pbg_r[i]} * {17'b0, bn_r};
      qtex_nxt[i] = mt[35:24];
      qbg_nxt[i]  = mb[35:24];
    end
  end

  // stage 3: remaining divide by five, then sum per channel
  always_comb begin
    logic [10:0] s;
    color_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      s = {1'b0, tsp_pkg::div5(qtex_r[i])} + {1'b0, tsp_pkg::div5(qbg_r[i])};
      color_nxt[23-8*i -: 8] = tsp_pkg::sat8(s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      bn_r    <= bn_nxt;
      surf1_r <= in_surface;
      ptex_r  <= ptex_nxt;
      pbg_r   <= pbg_nxt;
    end
    if (rdy2 && v1_r) begin
      surf2_r <= surf1_r;
      qtex_r  <= qtex_nxt;
      qbg_r   <= qbg_nxt;
    end
    if (rdy3 && v2_r) begin
      surf3_r <= surf2_r;
      color_r <= color_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tsp_tint.sv]
// time-of-day tint and halving, two register stages ending in the output register
// uses tsp_pkg
`default_nettype none

module tsp_tint (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire tsp_pkg::lit_t              up_word,
  output logic                            up_ready,
  input  wire logic [tsp_pkg::HOUR_W-1:0] hour,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [23:0]                out_shaded_color
);

  logic v4_r, v5_r;
  logic rdy4, rdy5;

  logic [17:0] pr_r;
  logic [18:0] pg_r, pb_r;
  logic        hi_r;
  logic [1:0]  surf4_r;
  logic [23:0] color4_r;
  logic [23:0] color5_r;

  logic        hi;
  logic [9:0]  fr;
  logic [10:0] fg, fb;
  logic [17:0] pr_nxt;
  logic [18:0] pg_nxt, pb_nxt;
  logic [23:0] color5_nxt;

  assign rdy5     = !v5_r || !out_stall;
  assign rdy4     = !v4_r || rdy5;
  assign up_ready = rdy4;

  assign out_valid        = v5_r;
  assign out_shaded_color = color5_r;

  // stage 4: per-channel tint products
  always_comb begin
    hi = (hour > tsp_pkg::HOUR_MID);
    fr = {1'b0, tsp_pkg::HOUR_MID} + {1'b0, hour};
    if (hi) begin
      // factors that would go negative clamp the channel to zero
      fg = (hour > tsp_pkg::HOUR_GREEN0) ? 11'd0 : {2'b0, tsp_pkg::HOUR_GREEN0 - hour};
      fb = (hour > tsp_pkg::HOUR_BLUE0)  ? 11'd0 : {2'b0, tsp_pkg::HOUR_BLUE0 - hour};
    end else begin
      fg = tsp_pkg::HOUR_LOW_K - {2'b0, hour};
      fb = fg;
    end
    pr_nxt = {10'b0, up_word.color[23:16]} * {8'b0, fr};
    pg_nxt = {11'b0, up_word.color[15:8]}  * {8'b0, fg};
    pb_nxt = {11'b0, up_word.color[7:0]}   * {8'b0, fb};
  end

  // stage 5: scale back, saturate, halve codes 2 and 3; surface 0 passes through
  always_comb begin
    logic [7:0] nr, ng, nb;
    logic [23:0] tinted;
    nr = tsp_pkg::sat8({1'b0, pr_r[17:8]});
    if (hi_r) begin
      ng = pg_r[15:8];
      nb = pb_r[14:7];
    end else begin
      // divide by 1280 as a shift by 8 then a divide by five
      ng = tsp_pkg::sat8({1'b0, tsp_pkg::div5({1'b0, pg_r[18:8]})});
      nb = tsp_pkg::sat8({1'b0, tsp_pkg::div5({1'b0, pb_r[18:8]})});
    end
    tinted = {nr, ng, nb};
    if (surf4_r == tsp_pkg::SURF_PASS) begin
      color5_nxt = color4_r;
    end else if (surf4_r[1]) begin
      color5_nxt = {1'b0, tinted[23:17], 1'b0, tinted[15:9], 1'b0, tinted[7:1]};
    end else begin
      color5_nxt = tinted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= up_word.valid;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && up_word.valid) begin
      pr_r     <= pr_nxt;
      pg_r     <= pg_nxt;
      pb_r     <= pb_nxt;
      hi_r     <= hi;
      surf4_r  <= up_word.surface;
      color4_r <= up_word.color;
    end
    if (rdy5 && v4_r) begin
      color5_r <= color5_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/texel_shade_pipeline.sv]
// texel shade pipeline top level: config registers, lighting stages, tint stages
// uses tsp_pkg, tsp_cfg, tsp_light, tsp_tint
//
// one texel word in, one shaded color word out, no state carried between words.
// input channel: in_valid / in_stall with texel bytes, alpha, background,
// distance and surface; a word is taken when in_valid is high and in_stall low.
// output channel: out_valid / out_stall with out_shaded_color; a word leaves
// when out_valid is high and out_stall low.
// five register stages: three of brightness and blend, two of tint and halving,
// the last being the output register. with no stall a word accepted at the input
// moves through the stages in order and shows on out_valid from the output register.
// throughput is one word per cycle while out_stall is low; every stage advances
// whenever the stage after it is empty or moving.
// when the receiver stalls, each stage holds its word and empty stages still
// fill, so in_stall only rises once all five stages hold a word.
// the hour register sits at byte address 0 of the apb port; pready is always high.
// reset (rst_n low, synchronous) empties the pipeline and sets the hour to 128.
`default_nettype none

module texel_shade_pipeline (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_texel_red,
  input  wire logic [7:0]  in_texel_green,
  input  wire logic [7:0]  in_texel_blue,
  input  wire logic [7:0]  in_texel_alpha,
  input  wire logic        in_has_alpha,
  input  wire logic [23:0] in_background,
  input  wire logic [15:0] in_distance,
  input  wire logic [1:0]  in_surface,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [23:0] out_shaded_color,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [tsp_pkg::HOUR_W-1:0] hour;
  tsp_pkg::lit_t              lit_word;
  logic                       lit_ready;

  tsp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .hour    (hour)
  );

  tsp_light u_light (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_texel_red   (in_texel_red),
    .in_texel_green (in_texel_green),
    .in_texel_blue  (in_texel_blue),
    .in_texel_alpha (in_texel_alpha),
    .in_has_alpha   (in_has_alpha),
    .in_background  (in_background),
    .in_distance    (in_distance),
    .in_surface     (in_surface),
    .dn_ready       (lit_ready),
    .dn_word        (lit_word)
  );

  tsp_tint u_tint (
    .clk              (clk),
    .rst_n            (rst_n),
    .up_word          (lit_word),
    .up_ready         (lit_ready),
    .hour             (hour),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_shaded_color (out_shaded_color)
  );

endmodule

`default_nettype wire

[hw/rtl/tsp_checker.sv]
// port-level checks for the texel shade pipeline, bound to the top level
// no dependencies beyond the top level's ports
`default_nettype none

module tsp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_texel_red,
  input wire logic [7:0]  in_texel_green,
  input wire logic [7:0]  in_texel_blue,
  input wire logic [7:0]  in_texel_alpha,
  input wire logic        in_has_alpha,
  input wire logic [23:0] in_background,
  input wire logic [15:0] in_distance,
  input wire logic [1:0]  in_surface,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [23:0] out_shaded_color,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // a stalled result word stays and holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_shaded_color))
    else $error("stalled output word changed or vanished");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output word present right after reset");

  // input backs up only when the output word is present and the receiver stalls
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the pipeline could advance");

  // an accepted word reaches the output when nothing stalls in between
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(in_valid && !in_stall && rst_n, 5) &&
     $past(rst_n && !out_stall, 4) && $past(rst_n && !out_stall, 3) &&
     $past(rst_n && !out_stall, 2) && $past(rst_n && !out_stall, 1)) |-> out_valid)
    else $error("accepted word did not reach the output in five cycles");

endmodule

bind texel_shade_pipeline tsp_checker u_tsp_checker (.*);

`default_nettype wire

[test/texel_shade_checker.sv]
// checker for the texel shade pipeline: watches the word channels and the apb port,
// predicts each shaded colour and compares it with what leaves the block
// depends on tsp_pkg for the hour register width, reset value and index and the pass-through surface code
`timescale 1ns / 1ps

module texel_shade_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_texel_red,
  input  logic [7:0]  in_texel_green,
  input  logic [7:0]  in_texel_blue,
  input  logic [7:0]  in_texel_alpha,
  input  logic        in_has_alpha,
  input  logic [23:0] in_background,
  input  logic [15:0] in_distance,
  input  logic [1:0]  in_surface,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [23:0] out_shaded_color,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          words_pending
);

  localparam logic [2:0]  HOUR_ADDR    = {tsp_pkg::REG_HOUR, 2'b00};
  localparam logic [63:0] BRIGHT_FLOOR = 64'd131072;
  localparam logic [63:0] BRIGHT_FULL  = 64'd327680;
  localparam logic [63:0] BRIGHT_SLOPE = 64'd50;
  localparam logic [63:0] ALPHA_FULL   = 64'd256;

  logic [tsp_pkg::HOUR_W-1:0] hour_reg;
  logic [23:0]                shade_q [$];
  int                         failures = 0;

  initial begin
    fail_count    = 0;
    words_pending = 0;
  end

  function automatic logic [7:0] clamp_byte(input logic [63:0] v);
    return (v > 64'd255) ? 8'hff : v[7:0];
  endfunction

  function automatic logic [23:0] shade_texel(
    input logic [23:0]                texel,
    input logic [7:0]                 alpha,
    input logic                       has_alpha,
    input logic [23:0]                backdrop,
    input logic [15:0]                depth,
    input logic [1:0]                 surf,
    input logic [tsp_pkg::HOUR_W-1:0] hour
  );
    logic [63:0] bright, den, c, k, sum;
    logic [63:0] r, g, b, h, nr, ng, nb;
    logic [23:0] color;
    int i;
    bright = BRIGHT_FLOOR + BRIGHT_SLOPE * 64'(depth);
    if (bright > BRIGHT_FULL) bright = BRIGHT_FULL;
    den = ALPHA_FULL * BRIGHT_FULL;
    for (i = 0; i < 3; i++) begin
      c = 64'(texel[8*(2-i) +: 8]);
      k = 64'(backdrop[8*(2-i) +: 8]);
      if (has_alpha) begin
        sum = (k * (ALPHA_FULL - 64'(alpha)) * bright) / den
            + (c * 64'(alpha) * bright) / den;
      end else begin
        sum = (c * bright) / BRIGHT_FULL;
      end
      color[8*(2-i) +: 8] = clamp_byte(sum);
    end
    if (surf != tsp_pkg::SURF_PASS) begin
      r = 64'(color[23:16]);
      g = 64'(color[15:8]);
      b = 64'(color[7:0]);
      h = 64'(hour);
      nr = (r * (64'd128 + h)) / 64'd256;
      if (h > 64'd128) begin
        // warm light: red up, green and blue down, floored at zero past their knees
        nr = clamp_byte(nr);
        ng = (h > 64'd384) ? 64'd0 : (g * (64'd384 - h)) / 64'd256;
        nb = (h > 64'd256) ? 64'd0 : (b * (64'd256 - h)) / 64'd128;
      end else begin
        ng = clamp_byte((g * (64'd1408 - h)) / 64'd1280);
        nb = clamp_byte((b * (64'd1408 - h)) / 64'd1280);
      end
      color = {nr[7:0], ng[7:0], nb[7:0]};
      // codes two and three both halve after the tint
      if (surf[1]) color = {1'b0, color[23:17], 1'b0, color[15:9], 1'b0, color[7:1]};
    end
    return color;
  endfunction

  task automatic note_failure(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    failures++;
    if (failures <= 10)
      $display("%0t %s: expected %06h got %06h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    logic [23:0] want;
    if (!rst_n) begin
      hour_reg = tsp_pkg::HOUR_RESET;
      shade_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == HOUR_ADDR) hour_reg = pwdata[tsp_pkg::HOUR_W-1:0];
        end else if (prdata !== {{(32-tsp_pkg::HOUR_W){1'b0}}, hour_reg}) begin
          note_failure("hour register readback",
                       {{(32-tsp_pkg::HOUR_W){1'b0}}, hour_reg}, prdata);
        end
      end
      if (in_valid && !in_stall)
        shade_q.push_back(shade_texel({in_texel_red, in_texel_green, in_texel_blue},
                                      in_texel_alpha, in_has_alpha, in_background,
                                      in_distance, in_surface, hour_reg));
      if (out_valid && !out_stall) begin
        if (shade_q.size() == 0) begin
          note_failure("shaded word with none outstanding", 32'd0,
                       32'(out_shaded_color));
        end else begin
          want = shade_q.pop_front();
          if (out_shaded_color !== want)
            note_failure("shaded color mismatch", 32'(want), 32'(out_shaded_color));
        end
      end
    end
    words_pending <= shade_q.size();
    fail_count    <= failures;
  end

endmodule

[test/texel_shade_pipeline_tb.sv]
// top of the texel shade pipeline testbench: clock, reset, stimulus and verdict
// depends on tsp_pkg, texel_shade_pipeline and texel_shade_checker
`timescale 1ns / 1ps

module texel_shade_pipeline_tb;

  localparam int PHASE_COUNT     = 8;
  localparam int WORDS_PER_PHASE = 75;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_CYCLES     = 120;
  localparam int DRAIN_CYCLES    = 10;
  localparam logic [2:0] HOUR_ADDR      = {tsp_pkg::REG_HOUR, 2'b00};
  localparam logic [1:0] SURF_TINT      = 2'd1;
  localparam logic [1:0] SURF_TINT_HALF = 2'd2;
  localparam logic [1:0] SURF_TINT_ALT  = 2'd3;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        has_alpha;
    logic [23:0] background;
    logic [15:0] distance;
    logic [1:0]  surface;
  } texel_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_texel_red;
  logic [7:0]  in_texel_green;
  logic [7:0]  in_texel_blue;
  logic [7:0]  in_texel_alpha;
  logic        in_has_alpha;
  logic [23:0] in_background;
  logic [15:0] in_distance;
  logic [1:0]  in_surface;
  logic        out_valid;
  logic        out_stall;
  logic [23:0] out_shaded_color;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int words_pending;
  int cycle_count = 0;
  int words_out   = 0;
  bit long_hold_done = 1'b0;

  texel_shade_pipeline dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_texel_red     (in_texel_red),
    .in_texel_green   (in_texel_green),
    .in_texel_blue    (in_texel_blue),
    .in_texel_alpha   (in_texel_alpha),
    .in_has_alpha     (in_has_alpha),
    .in_background    (in_background),
    .in_distance      (in_distance),
    .in_surface       (in_surface),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_shaded_color (out_shaded_color),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  texel_shade_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_texel_red     (in_texel_red),
    .in_texel_green   (in_texel_green),
    .in_texel_blue    (in_texel_blue),
    .in_texel_alpha   (in_texel_alpha),
    .in_has_alpha     (in_has_alpha),
    .in_background    (in_background),
    .in_distance      (in_distance),
    .in_surface       (in_surface),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_shaded_color (out_shaded_color),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .fail_count       (fail_count),
    .words_pending    (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_length();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic texel_word_t make_word(
    input logic [7:0] r, g, b, a,
    input logic ha,
    input logic [23:0] bg,
    input logic [15:0] depth,
    input logic [1:0] surf
  );
    texel_word_t w;
    w.red        = r;
    w.green      = g;
    w.blue       = b;
    w.alpha      = a;
    w.has_alpha  = ha;
    w.background = bg;
    w.distance   = depth;
    w.surface    = surf;
    return w;
  endfunction

  function automatic texel_word_t random_word();
    texel_word_t w;
    int pick;
    w.red        = 8'($urandom);
    w.green      = 8'($urandom);
    w.blue       = 8'($urandom);
    w.has_alpha  = 1'($urandom_range(0, 1));
    w.background = 24'($urandom);
    w.surface    = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 7);
    w.alpha = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
    // half the words below the brightness knee so dimming gets exercised
    w.distance = $urandom_range(0, 1) ? 16'($urandom_range(0, 4000)) : 16'($urandom);
    return w;
  endfunction

  task automatic send_word(input texel_word_t w, input bit allow_gaps);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (idle_length()) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_texel_red   <= w.red;
    in_texel_green <= w.green;
    in_texel_blue  <= w.blue;
    in_texel_alpha <= w.alpha;
    in_has_alpha   <= w.has_alpha;
    in_background  <= w.background;
    in_distance    <= w.distance;
    in_surface     <= w.surface;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= HOUR_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [8:0] hour;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_texel_red   <= '0;
    in_texel_green <= '0;
    in_texel_blue  <= '0;
    in_texel_alpha <= '0;
    in_has_alpha   <= 1'b0;
    in_background  <= '0;
    in_distance    <= '0;
    in_surface     <= tsp_pkg::SURF_PASS;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at the reset hour
    apb_access(1'b0, 32'd0);
    send_word(make_word(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 24'h000000, 16'h0000,
                        tsp_pkg::SURF_PASS), 1'b0);
    send_word(make_word(8'hff, 8'hff, 8'hff, 8'h00, 1'b0, 24'h000000, 16'hffff,
                        tsp_pkg::SURF_PASS), 1'b0);
    send_word(make_word(8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 24'hffffff, 16'hffff,
                        tsp_pkg::SURF_PASS), 1'b1);
    send_word(make_word(8'hff, 8'hff, 8'hff, 8'h00, 1'b1, 24'hffffff, 16'hffff,
                        tsp_pkg::SURF_PASS), 1'b0);
    send_word(make_word(8'h12, 8'h80, 8'hfe, 8'h00, 1'b1, 24'ha5c3e1, 16'h0000, SURF_TINT),
              1'b0);
    // alpha set but no alpha plane: weight ignored
    send_word(make_word(8'hc8, 8'h64, 8'h32, 8'hc8, 1'b0, 24'hffffff, 16'h1000,
                        tsp_pkg::SURF_PASS), 1'b1);
    send_word(make_word(8'hff, 8'hff, 8'hff, 8'h00, 1'b0, 24'h000000, 16'h0000,
                        tsp_pkg::SURF_PASS), 1'b0);
    send_word(make_word(8'hff, 8'hff, 8'hff, 8'h00, 1'b0, 24'h000000, 16'd3932,
                        tsp_pkg::SURF_PASS), 1'b0);
    send_word(make_word(8'hff, 8'hff, 8'hff, 8'h00, 1'b0, 24'h000000, 16'd3933,
                        tsp_pkg::SURF_PASS), 1'b0);
    send_word(make_word(8'hff, 8'hff, 8'hff, 8'h00, 1'b0, 24'h000000, 16'hffff, SURF_TINT),
              1'b1);
    send_word(make_word(8'hff, 8'hff, 8'hff, 8'h00, 1'b0, 24'h000000, 16'hffff,
                        SURF_TINT_HALF), 1'b0);
    send_word(make_word(8'hff, 8'hff, 8'hff, 8'h00, 1'b0, 24'h000000, 16'hffff,
                        SURF_TINT_ALT), 1'b0);
    send_word(make_word(8'h9a, 8'hbc, 8'hde, 8'h80, 1'b1, 24'h123456, 16'h0800, SURF_TINT),
              1'b1);
    send_word(make_word(8'h9a, 8'hbc, 8'hde, 8'h80, 1'b1, 24'h123456, 16'h0800,
                        SURF_TINT_HALF), 1'b0);
    send_word(make_word(8'h9a, 8'hbc, 8'hde, 8'h80, 1'b1, 24'h123456, 16'h0800,
                        SURF_TINT_ALT), 1'b0);
    send_word(make_word(8'h55, 8'haa, 8'h55, 8'h01, 1'b1, 24'haa55aa, 16'h5555, SURF_TINT),
              1'b0);
    send_word(make_word(8'haa, 8'h55, 8'haa, 8'hfe, 1'b1, 24'h55aa55, 16'haaaa,
                        tsp_pkg::SURF_PASS), 1'b1);
    send_word(make_word(8'h01, 8'h02, 8'h04, 8'h7f, 1'b1, 24'h804020, 16'h0001,
                        SURF_TINT_HALF), 1'b0);
    drain();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       hour = 9'd0;
        1:       hour = 9'd511;
        2:       hour = 9'd129;
        3:       hour = 9'd256;
        4:       hour = 9'd385;
        5:       hour = 9'd300;
        6:       hour = 9'd64;
        default: hour = 9'($urandom_range(0, 511));
      endcase
      apb_access(1'b1, {23'd0, hour});
      apb_access(1'b0, 32'd0);
      // every third phase the sender runs without gaps
      for (int n = 0; n < WORDS_PER_PHASE; n++) send_word(random_word(), (p % 3) != 2);
      drain();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side stalls; one long hold-off once traffic is flowing so the block backs up
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && words_out >= 150) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (idle_length()) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (out_valid && !out_stall) words_out <= words_out + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

[files.f]
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_cfg.sv
hw/rtl/tsp_light.sv
hw/rtl/tsp_tint.sv
hw/rtl/texel_shade_pipeline.sv
hw/rtl/tsp_checker.sv
test/texel_shade_checker.sv
test/texel_shade_pipeline_tb.sv
